/* rtl/linear_probe_hash_table_defines.svh */
// assertion macros for the linear probe hash table checker
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// same-cycle implication
`define LPHT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpht check failed");

// next-cycle implication
`define LPHT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpht check failed");

`endif

/* rtl/lpht_pkg.sv */
// shared constants and codes for the linear probe hash table
package lpht_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_W       = 31;
  localparam int CFG_W       = 11;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int SLOT_W      = 2;

  localparam int MOD_DIGIT = 4;
  localparam int MOD_STEPS = (KEY_W + MOD_DIGIT - 1) / MOD_DIGIT;
  localparam int MOD_PAD_W = MOD_STEPS * MOD_DIGIT;
  localparam int MOD_STEP_W = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;

  localparam logic [STATUS_W-1:0] RES_SUCCESS   = 2'd0;
  localparam logic [STATUS_W-1:0] RES_ABSENT    = 2'd1;
  localparam logic [STATUS_W-1:0] RES_DUPLICATE = 2'd2;
  localparam logic [STATUS_W-1:0] RES_FULL      = 2'd3;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY   = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_ACTIVE  = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_DELETED = 2'd2;

endpackage

/* rtl/lpht_mod_unit.sv */
// iterative remainder unit for the home slot, MOD_DIGIT quotient bits per cycle
module lpht_mod_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [lpht_pkg::KEY_W-1:0]  dividend,
  input  logic [lpht_pkg::CNT_W-1:0]  divisor,
  output logic                        done,
  output logic [lpht_pkg::IDX_W-1:0]  remainder
);
  import lpht_pkg::*;

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MOD_STEP_W-1:0] step_r, step_nxt;
  logic [CNT_W-1:0]      div_r, div_nxt;
  logic [MOD_PAD_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      rem_iter;
  logic [CNT_W:0]        trial;

  // MOD_DIGIT restoring steps per cycle on narrow values
  always_comb begin
    rem_iter = rem_r;
    trial    = '0;
    for (int i = 0; i < MOD_DIGIT; i++) begin
      trial = {rem_iter, num_r[MOD_PAD_W-1-i]};
      if (trial >= {1'b0, div_r}) begin
        trial = trial - {1'b0, div_r};
      end
      rem_iter = trial[CNT_W-1:0];
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    div_nxt  = div_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      div_nxt  = divisor;
      num_nxt  = MOD_PAD_W'(dividend);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = rem_iter;
      num_nxt  = num_r << MOD_DIGIT;
      step_nxt = step_r + 1'b1;
      if (step_r == MOD_STEP_W'(MOD_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    div_r <= div_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r[IDX_W-1:0];

endmodule

/* rtl/linear_probe_hash_table.sv */
// open addressing hash table with linear probing, top level
//
// usage: drive in_command and in_key and raise start while busy is low; the
// item is taken at that clock edge. one result follows per item, shown for a
// single cycle with out_strobe high; the receiver cannot hold it off.
// cfg_we with cfg_wdata sets the slot count; the user is bound to write it
// only while the block is idle, which the block itself does not enforce.
// zero acts as one and values above the table depth act as the depth. an
// insert refused for a full table, or an unknown command, answers in the
// cycle after start. otherwise the home slot remainder comes from the
// remainder unit (8 steps of 4 quotient bits, then the hand-off to the
// prober), then each slot visited takes a read, then a check and write.
// throughput: one item at a time; busy stays high until its result shows,
// but an item answered at once does not raise busy.
// reset: a clearing pass marks all 1024 slots empty, one slot a cycle, and
// busy stays high until the pass ends. the slot count resets to 1024 and
// the entry count to zero.
module linear_probe_hash_table (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [lpht_pkg::CMD_W-1:0]      in_command,
  input  logic [lpht_pkg::KEY_W-1:0]      in_key,
  output logic                            out_strobe,
  output logic [lpht_pkg::STATUS_W-1:0]   out_status,
  output logic [lpht_pkg::IDX_W-1:0]      out_slot_index,
  output logic [lpht_pkg::CNT_W-1:0]      out_probe_count,
  output logic [lpht_pkg::CNT_W-1:0]      out_entry_count_out,
  input  logic                            cfg_we,
  input  logic [lpht_pkg::CFG_W-1:0]      cfg_wdata
);
  import lpht_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK
  } state_t;

  localparam int WORD_W = KEY_W + SLOT_W;

  state_t              state_r, state_nxt;
  logic [IDX_W-1:0]    clr_idx_r, clr_idx_nxt;
  logic [CFG_W-1:0]    slots_cfg_r;
  logic [CNT_W-1:0]    n_r, n_nxt;
  logic [CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [IDX_W-1:0]    cur_r, cur_nxt;
  logic [CNT_W-1:0]    steps_r, steps_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_strobe_r, out_strobe_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [IDX_W-1:0]    out_slot_r, out_slot_nxt;
  logic [CNT_W-1:0]    out_probe_r, out_probe_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;

  logic [WORD_W-1:0]   slot_mem [TABLE_DEPTH];
  logic [WORD_W-1:0]   rdata_r;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_waddr;
  logic [WORD_W-1:0]   mem_wdata;

  logic [CNT_W-1:0]    eff_n;
  logic                mod_start;
  logic                mod_done;
  logic [IDX_W-1:0]    mod_rem;
  logic [SLOT_W-1:0]   slot_st;
  logic                key_hit;
  logic [CNT_W-1:0]    steps_inc;
  logic [CNT_W-1:0]    cur_inc;

  lpht_mod_unit u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (in_key),
    .divisor   (eff_n),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  // clamp the configured slot count
  always_comb begin
    if (slots_cfg_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (CNT_W'(slots_cfg_r) > CNT_W'(TABLE_DEPTH)) begin
      eff_n = CNT_W'(TABLE_DEPTH);
    end else begin
      eff_n = CNT_W'(slots_cfg_r);
    end
  end

  assign slot_st   = rdata_r[WORD_W-1 -: SLOT_W];
  assign key_hit   = (rdata_r[KEY_W-1:0] == key_r);
  assign steps_inc = steps_r + 1'b1;
  assign cur_inc   = CNT_W'(cur_r) + 1'b1;

  always_comb begin
    state_nxt      = state_r;
    clr_idx_nxt    = clr_idx_r;
    n_nxt          = n_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    steps_nxt      = steps_r;
    count_nxt      = count_r;
    out_strobe_nxt = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_probe_nxt  = out_probe_r;
    out_count_nxt  = out_count_r;
    mod_start      = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = cur_r;
    mem_wdata      = {SLOT_ACTIVE, key_r};

    case (state_r)
      S_CLEAR: begin
        mem_we      = 1'b1;
        mem_waddr   = clr_idx_r;
        mem_wdata   = {SLOT_EMPTY, {KEY_W{1'b0}}};
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == IDX_W'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd_nxt   = in_command;
          key_nxt   = in_key;
          n_nxt     = eff_n;
          steps_nxt = '0;
          if (in_command == CMD_INSERT && count_r >= eff_n) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = RES_FULL;
            out_slot_nxt   = '0;
            out_probe_nxt  = '0;
            out_count_nxt  = count_r;
          end else if (in_command != CMD_INSERT && in_command != CMD_REMOVE &&
                       in_command != CMD_FIND) begin
            out_strobe_nxt = 1'b1;
            out_status_nxt = RES_ABSENT;
            out_slot_nxt   = '0;
            out_probe_nxt  = '0;
            out_count_nxt  = count_r;
          end else begin
            mod_start = 1'b1;
            state_nxt = S_HASH;
          end
        end
      end
      S_HASH: begin
        if (mod_done) begin
          cur_nxt   = mod_rem;
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_r == CMD_INSERT && (slot_st == SLOT_EMPTY || slot_st == SLOT_DELETED)) begin
          mem_we         = 1'b1;
          mem_wdata      = {SLOT_ACTIVE, key_r};
          count_nxt      = count_r + 1'b1;
          out_strobe_nxt = 1'b1;
          out_status_nxt = RES_SUCCESS;
          out_slot_nxt   = cur_r;
          out_probe_nxt  = steps_r;
          out_count_nxt  = count_r + 1'b1;
          state_nxt      = S_IDLE;
        end else if (cmd_r == CMD_INSERT && key_hit) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = RES_DUPLICATE;
          out_slot_nxt   = cur_r;
          out_probe_nxt  = steps_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end else if (cmd_r != CMD_INSERT && slot_st == SLOT_EMPTY) begin
          out_strobe_nxt = 1'b1;
          out_status_nxt = RES_ABSENT;
          out_slot_nxt   = '0;
          out_probe_nxt  = steps_r;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end else if (cmd_r != CMD_INSERT && key_hit) begin
          out_strobe_nxt = 1'b1;
          out_probe_nxt  = steps_r;
          state_nxt      = S_IDLE;
          if (slot_st == SLOT_ACTIVE) begin
            out_status_nxt = RES_SUCCESS;
            out_slot_nxt   = cur_r;
            if (cmd_r == CMD_REMOVE) begin
              mem_we    = 1'b1;
              mem_wdata = {SLOT_DELETED, key_r};
              if (count_r != '0) begin
                count_nxt = count_r - 1'b1;
              end
            end
          end else begin
            out_status_nxt = RES_ABSENT;
            out_slot_nxt   = '0;
          end
          out_count_nxt = count_nxt;
        end else if (steps_inc == n_r) begin
          // full lap without a stopping slot
          out_strobe_nxt = 1'b1;
          out_status_nxt = (cmd_r == CMD_INSERT) ? RES_FULL : RES_ABSENT;
          out_slot_nxt   = '0;
          out_probe_nxt  = steps_inc;
          out_count_nxt  = count_r;
          state_nxt      = S_IDLE;
        end else begin
          steps_nxt = steps_inc;
          cur_nxt   = (cur_inc == n_r) ? '0 : cur_inc[IDX_W-1:0];
          state_nxt = S_READ;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_idx_r    <= clr_idx_nxt;
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    n_r          <= n_nxt;
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    steps_r      <= steps_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_probe_r  <= out_probe_nxt;
    out_count_r  <= out_count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= CFG_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      slots_cfg_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= slot_mem[cur_r];
  end

  assign busy                = (state_r != S_IDLE);
  assign out_strobe          = out_strobe_r;
  assign out_status          = out_status_r;
  assign out_slot_index      = out_slot_r;
  assign out_probe_count     = out_probe_r;
  assign out_entry_count_out = out_count_r;

endmodule

/* rtl/lpht_checker.sv */
// port level checks for the linear probe hash table and their binding
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input logic [lpht_pkg::STATUS_W-1:0]   out_status,
  input logic [lpht_pkg::CNT_W-1:0]      out_probe_count,
  input logic [lpht_pkg::CNT_W-1:0]      out_entry_count_out
);
  import lpht_pkg::*;

  // result comes back with the block already idle
  `LPHT_ASSERT_NOW(a_strobe_idle, out_strobe, !busy)

  // an accepted item either starts work or answers at once
  `LPHT_ASSERT_NEXT(a_item_taken, start && !busy, busy || out_strobe)

  // every result traces to work in progress or an item just taken
  `LPHT_ASSERT_NOW(a_strobe_cause, out_strobe, $past(busy) || $past(start))

  // a duplicate means an active entry exists
  `LPHT_ASSERT_NOW(a_dup_count, out_strobe && out_status == RES_DUPLICATE,
                   out_entry_count_out != '0)

  // probe count never exceeds one lap
  `LPHT_ASSERT_NOW(a_probe_range, out_strobe, out_probe_count <= CNT_W'(TABLE_DEPTH))

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (.*);
